// ===== rtl/core/old_pkg.sv =====
// Shared constants, codes and types for the ordered list delete engine.
`timescale 1ns / 1ps

package old_pkg;

    localparam int MAX_ENTRIES = 16;
    localparam int IDX_W  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);
    localparam int DATA_W = 32;
    localparam int FUNC_W = 3;
    localparam int STAT_W = 2;

    typedef logic [FUNC_W-1:0]        t_func;
    typedef logic [STAT_W-1:0]        t_status;
    typedef logic [IDX_W-1:0]         t_idx;
    typedef logic [CNT_W-1:0]         t_cnt;
    typedef logic signed [DATA_W-1:0] t_data;

    localparam t_func FN_APPEND    = 3'd0;
    localparam t_func FN_DEL_FRONT = 3'd1;
    localparam t_func FN_DEL_LAST  = 3'd2;
    localparam t_func FN_DEL_KEY   = 3'd3;
    localparam t_func FN_DUMP      = 3'd4;

    localparam t_status ST_OK    = 2'd0;
    localparam t_status ST_EMPTY = 2'd1;
    localparam t_status ST_NOKEY = 2'd2;
    localparam t_status ST_FULL  = 2'd3;

endpackage

// ===== rtl/core/old_store.sv =====
// Entry storage: one write port and one read port with registered read data.
`timescale 1ns / 1ps

module old_store (
    input  logic          i_clk,
    input  logic          i_we,
    input  old_pkg::t_idx  i_waddr,
    input  old_pkg::t_data i_wdata,
    input  old_pkg::t_idx  i_raddr,
    output old_pkg::t_data o_rdata
);
    import old_pkg::*;

    t_data r_mem [MAX_ENTRIES];
    t_data r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/ordered_list_delete_engine_unit.sv =====
// Top level of the ordered list delete engine: request sequencer around the entry store.
//
//   channel   signals                                      direction
//   request   start, busy, i_func, i_item_value,           in
//             i_key_value
//   result    o_strobe, o_status, o_entry_value,           out
//             o_entry_count, o_last
//
// Append, delete last, any request on an empty list and unused codes are handled
// in the idle state and leave busy low. Delete front, delete key and dump walk the store
// through its single read port, one entry a cycle, and hold busy until the tail entry
// has been handled. Each result is registered and appears in the cycle after the step that makes it.
// Reset is synchronous and clears the list; the receiver cannot stall results.
`timescale 1ns / 1ps

module ordered_list_delete_engine_unit (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  old_pkg::t_func        i_func,
    input  old_pkg::t_data        i_item_value,
    input  old_pkg::t_data        i_key_value,
    output logic                  o_strobe,
    output old_pkg::t_status      o_status,
    output old_pkg::t_data        o_entry_value,
    output old_pkg::t_cnt         o_entry_count,
    output logic                  o_last
);
    import old_pkg::*;

    localparam logic S_IDLE = 1'b0;
    localparam logic S_SCAN = 1'b1;

    logic    r_state, n_state;
    t_cnt    r_count, n_count;
    t_func   r_func, n_func;
    t_data   r_key, n_key;
    t_cnt    r_rd_cnt, n_rd_cnt;
    logic    r_pend, n_pend;
    t_idx    r_pidx, n_pidx;
    logic    r_found, n_found;
    logic    r_strobe, n_strobe;
    t_status r_status, n_status;
    t_data   r_value, n_value;
    t_cnt    r_ecount, n_ecount;
    logic    r_last, n_last;

    logic    accept;
    logic    match;
    logic    is_tail;
    logic    mem_we;
    t_idx    mem_waddr;
    t_data   mem_wdata;
    t_idx    mem_raddr;
    t_data   mem_rdata;

    old_store u_store (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    assign busy   = (r_state == S_SCAN);
    assign accept = start & ~busy;

    assign match   = (r_func == FN_DEL_FRONT) || (mem_rdata == r_key);
    assign is_tail = (t_cnt'(r_pidx) == (r_count - t_cnt'(1)));

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_func    = r_func;
        n_key     = r_key;
        n_rd_cnt  = r_rd_cnt;
        n_pend    = 1'b0;
        n_pidx    = r_pidx;
        n_found   = r_found;
        n_strobe  = 1'b0;
        n_status  = ST_OK;
        n_value   = '0;
        n_ecount  = r_count;
        n_last    = 1'b1;
        mem_we    = 1'b0;
        mem_waddr = r_count[IDX_W-1:0];
        mem_wdata = i_item_value;
        mem_raddr = r_rd_cnt[IDX_W-1:0];

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_func = i_func;
                    n_key  = i_key_value;
                    case (i_func)
                        FN_APPEND: begin
                            n_strobe = 1'b1;
                            if (r_count == t_cnt'(MAX_ENTRIES)) begin
                                n_status = ST_FULL;
                            end else begin
                                mem_we   = 1'b1;
                                n_count  = r_count + t_cnt'(1);
                                n_ecount = r_count + t_cnt'(1);
                            end
                        end
                        FN_DEL_LAST: begin
                            n_strobe = 1'b1;
                            if (r_count == '0) begin
                                n_status = ST_EMPTY;
                            end else begin
                                n_count  = r_count - t_cnt'(1);
                                n_ecount = r_count - t_cnt'(1);
                            end
                        end
                        FN_DEL_FRONT, FN_DEL_KEY, FN_DUMP: begin
                            if (r_count == '0) begin
                                n_strobe = 1'b1;
                                n_status = ST_EMPTY;
                            end else begin
                                mem_raddr = '0;
                                n_rd_cnt  = t_cnt'(1);
                                n_pend    = 1'b1;
                                n_pidx    = '0;
                                n_found   = 1'b0;
                                n_state   = S_SCAN;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_SCAN: begin
                if (r_rd_cnt < r_count) begin
                    n_pend   = 1'b1;
                    n_pidx   = r_rd_cnt[IDX_W-1:0];
                    n_rd_cnt = r_rd_cnt + t_cnt'(1);
                end
                if (r_pend) begin
                    if (r_func == FN_DUMP) begin
                        n_strobe = 1'b1;
                        n_value  = mem_rdata;
                        n_last   = is_tail;
                    end else begin
                        if (r_found) begin
                            mem_we    = 1'b1;
                            mem_waddr = r_pidx - t_idx'(1);
                            mem_wdata = mem_rdata;
                        end else if (match) begin
                            n_found = 1'b1;
                        end
                        if (is_tail) begin
                            n_strobe = 1'b1;
                            if (r_found || match) begin
                                n_count  = r_count - t_cnt'(1);
                                n_ecount = r_count - t_cnt'(1);
                            end else begin
                                n_status = ST_NOKEY;
                            end
                        end
                    end
                    if (is_tail) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_pend   <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_pend   <= n_pend;
            r_strobe <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_func   <= n_func;
        r_key    <= n_key;
        r_rd_cnt <= n_rd_cnt;
        r_pidx   <= n_pidx;
        r_found  <= n_found;
        r_status <= n_status;
        r_value  <= n_value;
        r_ecount <= n_ecount;
        r_last   <= n_last;
    end

    assign o_strobe      = r_strobe;
    assign o_status      = r_status;
    assign o_entry_value = r_value;
    assign o_entry_count = r_ecount;
    assign o_last        = r_last;

endmodule
